@@ rtl/clock_setting_button_controller_unit_macros.svh @@
// Assertion macros shared by the clock set-up button controller RTL.
// Included by each module that carries concurrent assertions; no other dependencies.
// Defining ASSERT_OFF removes every check.
`ifndef CLOCK_SETTING_BUTTON_CONTROLLER_UNIT_MACROS_SVH
`define CLOCK_SETTING_BUTTON_CONTROLLER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Check on every clock edge outside reset
`define CSBC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("csbc: assertion failed");
// Check on every clock edge, reset included
`define CSBC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("csbc: assertion failed");
`else
`define CSBC_ASSERT(lbl, clk, rst_n, prop)
`define CSBC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

@@ rtl/csbc_pkg.sv @@
// Package for the clock set-up button controller: item types, mode codes, field limits.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package csbc_pkg;

  // Configuration register width (long-press tick count)
  localparam int unsigned CfgW = 4;
  localparam logic [CfgW-1:0] LONG_PRESS_RESET = 4'd8;

  // Item command codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  // Operating modes
  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ALARM  = 2'd1,
    MODE_SETUP  = 2'd2
  } mode_e;

  // Field limits applied on an up press: value at or above LIMIT becomes TOP
  localparam logic [7:0] HOUR_LIMIT   = 8'd24;
  localparam logic [7:0] HOUR_TOP     = 8'd23;
  localparam logic [7:0] MINSEC_LIMIT = 8'd60;
  localparam logic [7:0] MINSEC_TOP   = 8'd59;
  localparam logic [7:0] MONTH_LIMIT  = 8'd13;
  localparam logic [7:0] MONTH_TOP    = 8'd12;
  localparam logic [7:0] DAY_LIMIT    = 8'd31;
  localparam logic [7:0] DAY_TOP      = 8'd30;

  // Last cursor position before wrapping to zero
  localparam logic [1:0] CURSOR_LAST = 2'd2;

  // Input item
  typedef struct packed {
    logic       command;
    logic       btn_mode;
    logic       btn_up;
    logic       btn_down;
    logic       btn_page;
    logic [4:0] rtc_hour;
    logic [5:0] rtc_minute;
    logic [5:0] rtc_second;
    logic [4:0] rtc_day;
    logic [3:0] rtc_month;
    logic [6:0] rtc_year;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] field_cursor;
    logic       date_page;
    logic       write_clock;
    logic [4:0] out_hour;
    logic [5:0] out_minute;
    logic [5:0] out_second;
    logic [4:0] out_day;
    logic [3:0] out_month;
    logic [7:0] out_year;
    logic       alarm_match;
  } out_item_t;

  // One set of clock fields: hour, minute, second, day, month, year (time set or alarm set)
  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [4:0] day;
    logic [3:0] month;
    logic [7:0] year;
  } field_set_t;

endpackage

`default_nettype wire

@@ rtl/clock_setting_button_controller_unit.sv @@
// Clock set-up button controller: mode machine, field cursor and time/alarm field sets.
// Use: items come in on in_*, one result item per input item leaves on out_*.
// Input items are button ticks (command 0) or RTC loads (command 1); an item is taken
// at a clock edge with in_valid_i high and in_stall_o low, and a result likewise with
// out_valid_o high and out_stall_i low.
// Path: an accepted item passes the input register, then the update logic into the result
// register, whose valid flag drives out_valid_o.
// Throughput: one item per cycle while out_stall_i is low; the state update is a single
// pass of logic between the input register and the result register.
// Stall: while out_stall_i is high a full result register holds its item; an empty input
// register still takes one more item, then in_stall_o rises until the result is taken.
// Reset (rst_ni low, asynchronous): normal mode, cursor 0, time page, both field sets
// zero, long-press count 8, both registers empty.
// Configuration: cfg_we_i writes cfg_data_i to the long-press count; write only idle.
// Depends on csbc_pkg, csbc_in_reg, csbc_update and csbc_out_reg.
`timescale 1ns / 1ps
`default_nettype none

module clock_setting_button_controller_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [csbc_pkg::CfgW-1:0]  cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  csbc_pkg::in_item_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output csbc_pkg::out_item_t        out_data_o
);
  import csbc_pkg::*;

  logic      pend_valid;
  in_item_t  pend_item;
  logic      advance;
  out_item_t res;

  // Input register
  csbc_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .advance_i  (advance),
    .valid_o    (pend_valid),
    .data_o     (pend_item)
  );

  // State update
  csbc_update u_update (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .advance_i  (advance),
    .item_i     (pend_item),
    .res_o      (res)
  );

  // Result register
  csbc_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pend_valid_i (pend_valid),
    .res_i        (res),
    .advance_o    (advance),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire

@@ rtl/csbc_in_reg.sv @@
// Input register of the clock set-up button controller: holds one item until processed.
// Depends on csbc_pkg and the shared assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "clock_setting_button_controller_unit_macros.svh"

module csbc_in_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  csbc_pkg::in_item_t  in_data_i,
  input  logic                advance_i,
  output logic                valid_o,
  output csbc_pkg::in_item_t  data_o
);
  import csbc_pkg::*;

  logic     valid_q;
  in_item_t data_q;
  logic     load;

  // Register is free when empty or when its item moves on this cycle
  assign load       = !valid_q || advance_i;
  assign in_stall_o = !load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= in_valid_i;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

  // Stall only ever holds back a full register
  `CSBC_ASSERT(a_stall_needs_item, clk_i, rst_ni, in_stall_o |-> valid_q)
  // A held item is not lost while stalled
  `CSBC_ASSERT(a_held_item_kept, clk_i, rst_ni, valid_q && !advance_i |=> valid_q)

endmodule

`default_nettype wire

@@ rtl/csbc_update.sv @@
// Update logic of the clock set-up button controller: mode machine, cursor, page and both
// field sets, plus the long-press register. Depends on csbc_pkg and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "clock_setting_button_controller_unit_macros.svh"

module csbc_update (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [csbc_pkg::CfgW-1:0]      cfg_data_i,
  input  logic                           advance_i,
  input  csbc_pkg::in_item_t             item_i,
  output csbc_pkg::out_item_t            res_o
);
  import csbc_pkg::*;

  // One field step: increment, or decrement stopping at zero, then optional clamp
  function automatic logic [7:0] step8(logic [7:0] v, logic inc, logic dec, logic clamp,
                                       logic [7:0] limit, logic [7:0] top);
    logic [7:0] r;
    r = v;
    if (inc) begin
      r = v + 8'd1;
    end else if (dec && (v != 8'd0)) begin
      r = v - 8'd1;
    end
    if (clamp && (r >= limit)) begin
      r = top;
    end
    return r;
  endfunction

  // Step a whole set; bit order of inc/dec: hour, minute, second, day, month, year
  function automatic field_set_t adjust_set(field_set_t s, logic [5:0] inc, logic [5:0] dec,
                                            logic clamp_time, logic clamp_date);
    field_set_t r;
    logic [7:0] h, mi, se, dy, mo, yr;
    h  = step8({3'b0, s.hour}, inc[0], dec[0], clamp_time, HOUR_LIMIT, HOUR_TOP);
    mi = step8({2'b0, s.minute}, inc[1], dec[1], clamp_time, MINSEC_LIMIT, MINSEC_TOP);
    se = step8({2'b0, s.second}, inc[2], dec[2], clamp_time, MINSEC_LIMIT, MINSEC_TOP);
    dy = step8({3'b0, s.day}, inc[3], dec[3], clamp_date, DAY_LIMIT, DAY_TOP);
    mo = step8({4'b0, s.month}, inc[4], dec[4], clamp_date, MONTH_LIMIT, MONTH_TOP);
    yr = step8(s.year, inc[5], dec[5], 1'b0, 8'hFF, 8'hFF);
    r.hour   = h[4:0];
    r.minute = mi[5:0];
    r.second = se[5:0];
    r.day    = dy[4:0];
    r.month  = mo[3:0];
    r.year   = yr;
    return r;
  endfunction

  logic [CfgW-1:0] long_press_q;
  mode_e           mode_q, mode_d, mode_mid;
  logic [3:0]      hold_q, hold_d, hold_inc;
  logic            flag_q, flag_d;
  logic [1:0]      cursor_q, cursor_d;
  logic            page_q, page_d;
  field_set_t      time_q, time_d, alarm_q, alarm_d;
  logic [2:0]      field_idx;
  logic [5:0]      sel;
  logic            press_up, press_down, press_page;
  logic [5:0]      inc_t, inc_a, dec_t, dec_a;

  // Long-press register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_q <= LONG_PRESS_RESET;
    end else if (cfg_we_i) begin
      long_press_q <= cfg_data_i;
    end
  end

  // Button priority after the mode button: up, then down, then page
  assign press_up   = item_i.btn_up;
  assign press_down = !item_i.btn_up && item_i.btn_down;
  assign press_page = !item_i.btn_up && !item_i.btn_down && item_i.btn_page;
  assign hold_inc   = hold_q + 4'd1;

  // Next state: an RTC load (ignored outside normal mode), else mode button first, then up/down/page
  always_comb begin
    mode_mid   = mode_q;
    mode_d     = mode_q;
    hold_d     = hold_q;
    flag_d     = flag_q;
    cursor_d   = cursor_q;
    page_d     = page_q;
    time_d     = time_q;
    alarm_d    = alarm_q;
    field_idx  = 3'd0;
    sel        = 6'd0;
    inc_t      = 6'd0;
    inc_a      = 6'd0;
    dec_t      = 6'd0;
    dec_a      = 6'd0;
    if (item_i.command == CMD_LOAD) begin
      // RTC reading is taken only in normal mode
      if (mode_q == MODE_NORMAL) begin
        time_d.hour   = item_i.rtc_hour;
        time_d.minute = item_i.rtc_minute;
        time_d.second = item_i.rtc_second;
        time_d.day    = item_i.rtc_day;
        time_d.month  = item_i.rtc_month;
        time_d.year   = {1'b0, item_i.rtc_year};
      end
    end else begin
      // Mode button: long-press counting in normal mode, cursor step elsewhere
      if (item_i.btn_mode) begin
        if (mode_q == MODE_NORMAL) begin
          if (hold_inc >= long_press_q) begin
            hold_d   = 4'd0;
            mode_mid = MODE_ALARM;
            flag_d   = 1'b0;
          end else begin
            hold_d = hold_inc;
            flag_d = 1'b1;
          end
        end else begin
          cursor_d = (cursor_q >= CURSOR_LAST) ? 2'd0 : cursor_q + 2'd1;
        end
      end else if (flag_q) begin
        // Released before the long-press count: enter setup
        mode_mid = MODE_SETUP;
        flag_d   = 1'b0;
        hold_d   = 4'd0;
        cursor_d = 2'd0;
      end

      // Selected field: cursor on the time page, cursor + 3 on the date page
      field_idx = page_q ? {1'b0, cursor_d} + 3'd3 : {1'b0, cursor_d};
      sel       = 6'd1 << field_idx;
      inc_t     = (press_up && (mode_mid == MODE_SETUP)) ? sel : 6'd0;
      inc_a     = (press_up && (mode_mid == MODE_ALARM)) ? sel : 6'd0;
      dec_t     = (press_down && (mode_mid == MODE_SETUP)) ? sel : 6'd0;
      dec_a     = (press_down && (mode_mid == MODE_ALARM)) ? sel : 6'd0;
      time_d    = adjust_set(time_q, inc_t, dec_t, press_up && !page_q, press_up && page_q);
      alarm_d   = adjust_set(alarm_q, inc_a, dec_a, press_up && !page_q, press_up && page_q);

      mode_d = mode_mid;
      // Page: to the date page, or back to the time page and normal mode
      if (press_page) begin
        if (page_q) begin
          page_d = 1'b0;
          mode_d = MODE_NORMAL;
        end else begin
          page_d = 1'b1;
        end
      end
    end
  end

  // Result of the item, taken from the updated state
  always_comb begin
    res_o.mode         = mode_d;
    res_o.field_cursor = cursor_d;
    res_o.date_page    = page_d;
    res_o.write_clock  = (mode_q == MODE_SETUP) && (mode_d != MODE_SETUP);
    res_o.out_hour     = time_d.hour;
    res_o.out_minute   = time_d.minute;
    res_o.out_second   = time_d.second;
    res_o.out_day      = time_d.day;
    res_o.out_month    = time_d.month;
    res_o.out_year     = time_d.year;
    res_o.alarm_match  = (time_d == alarm_d);
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_NORMAL;
      hold_q   <= 4'd0;
      flag_q   <= 1'b0;
      cursor_q <= 2'd0;
      page_q   <= 1'b0;
      time_q   <= '0;
      alarm_q  <= '0;
    end else if (advance_i) begin
      mode_q   <= mode_d;
      hold_q   <= hold_d;
      flag_q   <= flag_d;
      cursor_q <= cursor_d;
      page_q   <= page_d;
      time_q   <= time_d;
      alarm_q  <= alarm_d;
    end
  end

  // A pending long press only exists in normal mode
  `CSBC_ASSERT(a_hold_in_normal, clk_i, rst_ni, flag_q |-> (mode_q == MODE_NORMAL))
  // Write strobe only when leaving setup
  `CSBC_ASSERT(a_write_from_setup, clk_i, rst_ni, advance_i && res_o.write_clock |-> (mode_q == MODE_SETUP))
  // Up press on the time page leaves the hour clamped
  `CSBC_ASSERT(a_hour_clamped, clk_i, rst_ni, advance_i && (item_i.command == CMD_TICK) && item_i.btn_up && !page_q |=> ({3'b0, time_q.hour} <= HOUR_TOP))
  // Cursor never reaches the unused code; reset may still be settling the register
  `CSBC_ASSERT_ALWAYS(a_cursor_range, clk_i, !rst_ni || (cursor_q != 2'd3))

endmodule

`default_nettype wire

@@ rtl/csbc_out_reg.sv @@
// Result register of the clock set-up button controller, with the advance decision.
// Depends on csbc_pkg and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "clock_setting_button_controller_unit_macros.svh"

module csbc_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 pend_valid_i,
  input  csbc_pkg::out_item_t  res_i,
  output logic                 advance_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output csbc_pkg::out_item_t  out_data_o
);
  import csbc_pkg::*;

  logic      valid_q;
  out_item_t data_q;

  // A pending item moves when the result register is empty or being taken
  assign advance_o = pend_valid_i && (!valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || !out_stall_i) begin
      valid_q <= pend_valid_i;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  // An item that moves always lands in the result register
  `CSBC_ASSERT(a_advance_lands, clk_i, rst_ni, advance_o |=> valid_q)

endmodule

`default_nettype wire
